>>> rtl/itba_pkg.sv
package itba_pkg;

  // field widths
  localparam int TIME_W  = 21;
  localparam int RATE_W  = 18;
  localparam int IDX_W   = 12;
  localparam int INT_W   = 32;
  localparam int ACC_W   = 40;
  localparam int PRES_W  = 25;
  localparam int PROD_W  = TIME_W + RATE_W;
  localparam int BIN_W   = PROD_W - 16 + 1;
  localparam int VSQ_W   = 50;
  localparam int ROOT_W  = VSQ_W / 2;
  localparam int REM_W   = ROOT_W + 2;
  localparam int SQ_STEPS = ROOT_W;
  localparam int SQ_CNT_W = $clog2(SQ_STEPS);

  // defaults and constants
  localparam int BINS_DEF  = 4096;
  localparam int BANDS_DEF = 8;
  localparam int MAX_BANDS = 8;
  localparam logic [TIME_W-1:0] TIME_LIMIT = TIME_W'(1310720);
  localparam logic [8:0]        IMPEDANCE  = 9'd400;
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(44100);
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

  // op codes
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // per-cycle lane commands
  typedef struct packed {
    logic clr;   // write zero at address
    logic rd;    // read row
    logic acc;   // saturating add and write back
    logic prep;  // magnitude times impedance, start root
    logic step;  // one root digit
  } lane_ctl_t;

endpackage

>>> rtl/itba_lane.sv
module itba_lane #(
  parameter int BINS = itba_pkg::BINS_DEF,
  parameter int AW   = $clog2(BINS)
) (
  input  logic                                 clk,
  input  itba_pkg::lane_ctl_t                  ctl,
  input  logic [AW-1:0]                        addr,
  input  logic signed [itba_pkg::INT_W-1:0]    intensity,
  output logic [itba_pkg::PRES_W-1:0]          pressure
);

  localparam int ACC_W  = itba_pkg::ACC_W;
  localparam int VSQ_W  = itba_pkg::VSQ_W;
  localparam int ROOT_W = itba_pkg::ROOT_W;
  localparam int REM_W  = itba_pkg::REM_W;

  logic signed [ACC_W-1:0] mem [BINS];
  logic signed [ACC_W-1:0] rdata;

  logic signed [ACC_W:0]   sum;
  logic signed [ACC_W-1:0] sum_sat;
  logic [ACC_W-1:0]        mag;
  logic [VSQ_W-2:0]        vmul;
  logic [VSQ_W-1:0]        v;
  logic [ROOT_W-1:0]       root;
  logic [REM_W-1:0]        rem;
  logic                    sign;
  logic [REM_W-1:0]        rem_sh;
  logic [REM_W-1:0]        trial;
  logic [ROOT_W-1:0]       root_rnd;

  // saturating accumulate
  always_comb begin
    sum = (ACC_W+1)'(rdata) + (ACC_W+1)'(intensity);
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      sum_sat = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sum_sat = sum[ACC_W-1:0];
    end
  end

  // bin store, one write and one registered read
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      mem[addr] <= '0;
    end else if (ctl.acc) begin
      mem[addr] <= sum_sat;
    end
    if (ctl.rd) begin
      rdata <= mem[addr];
    end
  end

  // magnitude scaled by impedance
  always_comb begin
    mag  = rdata[ACC_W-1] ? (ACC_W)'(0) - rdata : rdata;
    vmul = (VSQ_W-1)'(mag) * (VSQ_W-1)'(itba_pkg::IMPEDANCE);
  end

  // restoring square root, one digit per step
  always_comb begin
    rem_sh = {rem[REM_W-3:0], v[VSQ_W-1:VSQ_W-2]};
    trial  = {root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (ctl.prep) begin
      v    <= {1'b0, vmul};
      sign <= rdata[ACC_W-1];
      root <= '0;
      rem  <= '0;
    end else if (ctl.step) begin
      v <= {v[VSQ_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // round to nearest and apply sign
  always_comb begin
    root_rnd = root + ROOT_W'(rem > REM_W'(root));
    pressure = sign ? itba_pkg::PRES_W'(0) - root_rnd : root_rnd;
  end

endmodule

>>> rtl/impulse_time_bin_accumulator.sv
// Time-binned impulse accumulator.
// Input channel (in_valid/in_stall) takes one op per transfer: add places
// an impulse into bin round(arrival_time*sample_rate) and adds the band
// intensities with saturation; read returns one bin as signed pressure;
// clear empties the store. Output channel (out_valid/out_stall) carries
// one result per read. sample_rate is written over cfg_valid/cfg_ready.
// Sequence: an add steps through accept, multiply, bin and row read and,
// if the bin is kept, write back. A read steps through accept, multiply,
// row read, root prepare, the square root in each band lane (25 digits,
// one digit per cycle) and a final state loading the output register.
// A clear, and reset, run a pass that writes zero to every row;
// in_stall stays high during it. Config writes are taken at any time.
// The output register holds its result while out_stall is high; a new
// item is still accepted, and the next read waits before loading it.
module impulse_time_bin_accumulator #(
  parameter int BINS  = itba_pkg::BINS_DEF,
  parameter int BANDS = itba_pkg::BANDS_DEF,
  parameter int LEN_W = $clog2(BINS + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [itba_pkg::RATE_W-1:0]        cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         op,
  input  logic [itba_pkg::TIME_W-1:0]        arrival_time,
  input  logic [itba_pkg::IDX_W-1:0]         bin_index,
  input  logic signed [itba_pkg::INT_W-1:0]  intensity_b0,
  input  logic signed [itba_pkg::INT_W-1:0]  intensity_b1,
  input  logic signed [itba_pkg::INT_W-1:0]  intensity_b2,
  input  logic signed [itba_pkg::INT_W-1:0]  intensity_b3,
  input  logic signed [itba_pkg::INT_W-1:0]  intensity_b4,
  input  logic signed [itba_pkg::INT_W-1:0]  intensity_b5,
  input  logic signed [itba_pkg::INT_W-1:0]  intensity_b6,
  input  logic signed [itba_pkg::INT_W-1:0]  intensity_b7,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               in_length,
  output logic [LEN_W-1:0]                   length_in_use,
  output logic signed [itba_pkg::PRES_W-1:0] pressure_b0,
  output logic signed [itba_pkg::PRES_W-1:0] pressure_b1,
  output logic signed [itba_pkg::PRES_W-1:0] pressure_b2,
  output logic signed [itba_pkg::PRES_W-1:0] pressure_b3,
  output logic signed [itba_pkg::PRES_W-1:0] pressure_b4,
  output logic signed [itba_pkg::PRES_W-1:0] pressure_b5,
  output logic signed [itba_pkg::PRES_W-1:0] pressure_b6,
  output logic signed [itba_pkg::PRES_W-1:0] pressure_b7
);

  localparam int AW     = $clog2(BINS);
  localparam int TIME_W = itba_pkg::TIME_W;
  localparam int RATE_W = itba_pkg::RATE_W;
  localparam int IDX_W  = itba_pkg::IDX_W;
  localparam int INT_W  = itba_pkg::INT_W;
  localparam int PRES_W = itba_pkg::PRES_W;
  localparam int PROD_W = itba_pkg::PROD_W;
  localparam int BIN_W  = itba_pkg::BIN_W;
  localparam int NB     = itba_pkg::MAX_BANDS;
  localparam int WW     = BIN_W + 2;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_BIN  = 3'd3;
  localparam logic [2:0] S_ACC  = 3'd4;
  localparam logic [2:0] S_PREP = 3'd5;
  localparam logic [2:0] S_SQ   = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]                  state;
  logic [2:0]                  state_next;
  logic [AW-1:0]               clr_cnt;
  logic [itba_pkg::SQ_CNT_W-1:0] sq_cnt;
  logic [RATE_W-1:0]           rate;
  logic [TIME_W-1:0]           latest;
  logic [1:0]                  op_q;
  logic [TIME_W-1:0]           time_q;
  logic [IDX_W-1:0]            idx_q;
  logic signed [INT_W-1:0]     int_in [NB];
  logic signed [INT_W-1:0]     int_q  [NB];
  logic [PROD_W-1:0]           prod;
  logic [AW-1:0]               addr_q;
  logic [AW-1:0]               lane_addr;
  logic [LEN_W-1:0]            len_q;
  logic                        in_len_q;
  logic                        idx_ok_q;
  logic signed [PRES_W-1:0]    lane_pres [NB];
  logic signed [PRES_W-1:0]    pres_q    [NB];
  itba_pkg::lane_ctl_t         ctl;

  logic                        in_xfer;
  logic                        out_xfer;
  logic                        out_free;
  logic [TIME_W-1:0]           clamped;
  logic [BIN_W-1:0]            bin;
  logic [WW-1:0]               bin_w;
  logic [WW-1:0]               bin_lim;
  logic [WW-1:0]               len_w;
  logic [WW-1:0]               idx_w;
  logic                        keep;
  logic [AW-1:0]               bin_addr;
  logic [AW-1:0]               idx_addr;
  logic [AW+WW-1:0]            bin_ext;
  logic [AW+WW-1:0]            idx_ext;

  assign int_in[0] = intensity_b0;
  assign int_in[1] = intensity_b1;
  assign int_in[2] = intensity_b2;
  assign int_in[3] = intensity_b3;
  assign int_in[4] = intensity_b4;
  assign int_in[5] = intensity_b5;
  assign int_in[6] = intensity_b6;
  assign int_in[7] = intensity_b7;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;
  assign out_free  = !out_valid || !out_stall;

  // bin placement, keep test and length in use
  always_comb begin
    clamped  = (time_q > itba_pkg::TIME_LIMIT) ? itba_pkg::TIME_LIMIT : time_q;
    bin      = BIN_W'((prod + itba_pkg::ROUND_HALF) >> 16);
    bin_w    = WW'(bin);
    bin_lim  = (WW'(rate) << 4) + (WW'(rate) << 2);
    idx_w    = WW'(idx_q);
    keep     = (bin_w <= bin_lim) && (bin_w < WW'(BINS));
    len_w    = (bin_w + WW'(1) > WW'(BINS)) ? WW'(BINS) : bin_w + WW'(1);
    bin_ext  = (AW+WW)'(bin);
    idx_ext  = (AW+WW)'(idx_q);
    bin_addr = bin_ext[AW-1:0];
    idx_addr = idx_ext[AW-1:0];
  end

  // lane commands and address
  always_comb begin
    ctl      = '0;
    ctl.clr  = (state == S_CLR);
    ctl.rd   = (state == S_BIN);
    ctl.acc  = (state == S_ACC);
    ctl.prep = (state == S_PREP);
    ctl.step = (state == S_SQ);
    case (state)
      S_CLR:   lane_addr = clr_cnt;
      S_BIN:   lane_addr = (op_q == itba_pkg::OP_READ) ? idx_addr : bin_addr;
      default: lane_addr = addr_q;
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR:  if (clr_cnt == AW'(BINS - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (in_xfer) begin
          if (op == itba_pkg::OP_ADD || op == itba_pkg::OP_READ) begin
            state_next = S_MUL;
          end else if (op == itba_pkg::OP_CLEAR) begin
            state_next = S_CLR;
          end
        end
      end
      S_MUL:  state_next = S_BIN;
      S_BIN: begin
        if (op_q == itba_pkg::OP_READ) begin
          state_next = S_PREP;
        end else begin
          state_next = keep ? S_ACC : S_IDLE;
        end
      end
      S_ACC:  state_next = S_IDLE;
      S_PREP: state_next = S_SQ;
      S_SQ:   if (sq_cnt == itba_pkg::SQ_CNT_W'(itba_pkg::SQ_STEPS - 1)) state_next = S_FIN;
      S_FIN:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      sq_cnt    <= '0;
      rate      <= itba_pkg::RATE_RESET;
      latest    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        rate <= cfg_data;
      end
      clr_cnt <= (state == S_CLR) ? clr_cnt + AW'(1) : '0;
      sq_cnt  <= (state == S_SQ) ? sq_cnt + itba_pkg::SQ_CNT_W'(1) : '0;
      if (in_xfer && op == itba_pkg::OP_CLEAR) begin
        latest <= '0;
      end else if (state == S_MUL && op_q == itba_pkg::OP_ADD && clamped > latest) begin
        latest <= clamped;
      end
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item and datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_q   <= op;
      time_q <= arrival_time;
      idx_q  <= bin_index;
      int_q  <= int_in;
    end
    if (state == S_MUL) begin
      prod <= (op_q == itba_pkg::OP_ADD) ? PROD_W'(time_q) * PROD_W'(rate)
                                         : PROD_W'(latest) * PROD_W'(rate);
    end
    if (state == S_BIN) begin
      addr_q   <= (op_q == itba_pkg::OP_READ) ? idx_addr : bin_addr;
      len_q    <= LEN_W'(len_w);
      in_len_q <= idx_w < len_w;
      idx_ok_q <= idx_w < WW'(BINS);
    end
  end

  // band lanes
  for (genvar b = 0; b < NB; b++) begin : g_band
    if (b < BANDS) begin : g_lane
      itba_lane #(.BINS(BINS), .AW(AW)) u_lane (
        .clk       (clk),
        .ctl       (ctl),
        .addr      (lane_addr),
        .intensity (int_q[b]),
        .pressure  (lane_pres[b])
      );
    end else begin : g_off
      assign lane_pres[b] = '0;
    end
  end

  // merge lanes into the output register
  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      in_length     <= in_len_q && idx_ok_q;
      length_in_use <= len_q;
      for (int b = 0; b < NB; b++) begin
        pres_q[b] <= idx_ok_q ? lane_pres[b] : '0;
      end
    end
  end

  assign pressure_b0 = pres_q[0];
  assign pressure_b1 = pres_q[1];
  assign pressure_b2 = pres_q[2];
  assign pressure_b3 = pres_q[3];
  assign pressure_b4 = pres_q[4];
  assign pressure_b5 = pres_q[5];
  assign pressure_b6 = pres_q[6];
  assign pressure_b7 = pres_q[7];

  // a clear transfer starts the zeroing pass
  a_clear_pass: assert property (@(posedge clk) disable iff (rst)
    in_xfer && op == itba_pkg::OP_CLEAR |=> state == S_CLR)
    else $error("clear did not start zeroing pass");

  // write back only follows a bin read
  a_acc_order: assert property (@(posedge clk) disable iff (rst)
    state == S_ACC |-> $past(state) == S_BIN)
    else $error("accumulate without prior read");

  // a reported length is never zero nor past the store
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> length_in_use != '0 && length_in_use <= LEN_W'(BINS))
    else $error("length in use out of range");

endmodule
